/* src/coo_sparse_matvec_accumulate_assert.svh */
// Assertion macros used by the top RTL file of the sparse matrix-vector block.
`ifndef COO_SPARSE_MATVEC_ACCUMULATE_ASSERT_SVH
`define COO_SPARSE_MATVEC_ACCUMULATE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define COO_SMV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define COO_SMV_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* src/coo_smv_pkg.sv */
`timescale 1ns / 1ps

package coo_smv_pkg;

  // Field widths
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FRAC_W = 16;
  // Truncated Q32.16 product and the accumulate sum with guard bits
  localparam int unsigned PROD_W = 2 * DATA_W - FRAC_W;
  localparam int unsigned SUM_W  = PROD_W + 1;

  // Saturation bounds
  localparam logic signed [DATA_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] ACC_MIN = 32'sh8000_0000;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBTRACT  = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE_X  = 2'd0,
    OP_PRESET   = 2'd1,
    OP_NONZERO  = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_RESP
  } state_e;

  // Sequencer to MAC
  typedef struct packed {
    logic valid;
    logic subtract;
  } mac_ctrl_t;

  // MAC to sequencer
  typedef struct packed {
    logic                     valid;
    logic                     sat;
    logic signed [DATA_W-1:0] sum;
  } mac_res_t;

endpackage

/* src/coo_smv_in_if.sv */
`timescale 1ns / 1ps

// Input channel: one command transaction.
interface coo_smv_in_if;
  logic                                        valid;
  logic                                        ready;
  logic [1:0]                                  operation;
  logic [coo_smv_pkg::IDX_W-1:0]               element_index;
  logic [coo_smv_pkg::IDX_W-1:0]               row_index;
  logic [coo_smv_pkg::IDX_W-1:0]               col_index;
  logic signed [coo_smv_pkg::DATA_W-1:0]       value;

  modport source (
    output valid, operation, element_index, row_index, col_index, value,
    input  ready
  );
  modport sink (
    input  valid, operation, element_index, row_index, col_index, value,
    output ready
  );
endinterface

/* src/coo_smv_out_if.sv */
`timescale 1ns / 1ps

// Output channel: one accumulator read-back transaction.
interface coo_smv_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [coo_smv_pkg::DATA_W-1:0] read_value;
  logic                                  overflow_seen;

  modport source (
    output valid, read_value, overflow_seen,
    input  ready
  );
  modport sink (
    input  valid, read_value, overflow_seen,
    output ready
  );
endinterface

/* src/coo_smv_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one read port, registered read data.
module coo_smv_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = $clog2(DEPTH),
  parameter int unsigned WIDTH  = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/coo_smv_mac.sv */
`timescale 1ns / 1ps

// Q16.16 multiply, then saturating accumulate.
// Stage 1 registers the truncated product; the sum is formed after it.
module coo_smv_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  coo_smv_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [coo_smv_pkg::DATA_W-1:0] value_i,
  input  logic signed [coo_smv_pkg::DATA_W-1:0] x_i,
  input  logic signed [coo_smv_pkg::DATA_W-1:0] acc_i,
  output coo_smv_pkg::mac_res_t                 res_o
);

  localparam int unsigned DataW = coo_smv_pkg::DATA_W;
  localparam int unsigned ProdW = coo_smv_pkg::PROD_W;
  localparam int unsigned SumW  = coo_smv_pkg::SUM_W;

  logic signed [2*DataW-1:0] full_prod;
  logic signed [2*DataW-1:0] shifted_prod;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [DataW-1:0]   acc_q;
  logic                      sub_q;
  logic                      valid_q;
  logic signed [SumW-1:0]    acc_ext;
  logic signed [SumW-1:0]    prod_ext;
  logic signed [SumW-1:0]    sum;
  logic                      ovf_hi;
  logic                      ovf_lo;

  // Full product, floor-truncated to Q32.16 by arithmetic shift
  assign full_prod    = value_i * x_i;
  assign shifted_prod = full_prod >>> coo_smv_pkg::FRAC_W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      prod_q <= shifted_prod[ProdW-1:0];
      acc_q  <= acc_i;
      sub_q  <= ctrl_i.subtract;
    end
  end

  // Accumulate at full width, then clamp
  assign acc_ext  = SumW'(acc_q);
  assign prod_ext = SumW'(prod_q);
  assign sum      = sub_q ? (acc_ext - prod_ext) : (acc_ext + prod_ext);
  assign ovf_hi   = !sum[SumW-1] && (|sum[SumW-2:DataW-1]);
  assign ovf_lo   = sum[SumW-1] && !(&sum[SumW-2:DataW-1]);

  always_comb begin
    res_o.valid = valid_q;
    res_o.sat   = ovf_hi || ovf_lo;
    if (ovf_hi) begin
      res_o.sum = coo_smv_pkg::ACC_MAX;
    end else if (ovf_lo) begin
      res_o.sum = coo_smv_pkg::ACC_MIN;
    end else begin
      res_o.sum = sum[DataW-1:0];
    end
  end

endmodule

/* src/coo_sparse_matvec_accumulate.sv */
`timescale 1ns / 1ps
// Channel | Dir | Payload                                              | Role
// in_i    | in  | operation, element_index, row_index, col_index, value | commands
// out_o   | out | read_value, overflow_seen                              | read-back
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i                        | mode registers
//
// Write-x and preset write their RAM as the command is taken; a nonzero steps
// through x and acc RAM read, registered multiply, accumulate and write back;
// a read fetches the accumulator, then waits on the output register if full.
// The nonzero path is an accumulator RAM read-modify-write.
// Reset clears control state and the sticky overflow flag; the RAMs are not
// cleared. A stalled output holds its result; a read behind it waits.

`include "coo_sparse_matvec_accumulate_assert.svh"

module coo_sparse_matvec_accumulate #(
  parameter int unsigned VEC_DEPTH = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  coo_smv_in_if.sink                                in_i,
  coo_smv_out_if.source                             out_o,
  input  logic                                      cfg_we_i,
  input  logic [coo_smv_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [coo_smv_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned AddrW = $clog2(VEC_DEPTH);
  localparam int unsigned DataW = coo_smv_pkg::DATA_W;

  coo_smv_pkg::state_e    state_q, state_d;
  coo_smv_pkg::op_e       op;
  coo_smv_pkg::mac_ctrl_t mac_ctrl;
  coo_smv_pkg::mac_res_t  mac_res;

  logic                    transpose_q;
  logic                    subtract_q;
  logic                    sat_flag_q;
  logic                    in_ready;
  logic                    in_fire;
  logic [coo_smv_pkg::IDX_W-1:0] tgt_idx;
  logic [coo_smv_pkg::IDX_W-1:0] src_idx;
  logic                    elem_ok;
  logic                    nz_ok;
  logic [AddrW-1:0]        elem_addr;
  logic [AddrW-1:0]        tgt_addr;
  logic [AddrW-1:0]        src_addr;
  logic [AddrW-1:0]        tgt_q;
  logic signed [DataW-1:0] value_q;
  logic                    rd_ok_q;
  logic                    x_we;
  logic                    x_re;
  logic                    acc_pre_we;
  logic                    acc_re;
  logic                    acc_we;
  logic [AddrW-1:0]        acc_waddr;
  logic [DataW-1:0]        acc_wdata;
  logic [AddrW-1:0]        acc_raddr;
  logic [DataW-1:0]        x_rdata;
  logic [DataW-1:0]        acc_rdata;
  logic                    out_load;
  logic                    out_valid_q;
  logic signed [DataW-1:0] read_value_q;
  logic                    overflow_q;

  // Command decode
  assign in_fire = in_i.valid && in_ready;
  assign op      = coo_smv_pkg::op_e'(in_i.operation);
  assign tgt_idx = transpose_q ? in_i.col_index : in_i.row_index;
  assign src_idx = transpose_q ? in_i.row_index : in_i.col_index;
  assign elem_ok = 32'(in_i.element_index) < VEC_DEPTH;
  assign nz_ok   = (32'(tgt_idx) < VEC_DEPTH) && (32'(src_idx) < VEC_DEPTH);

  assign elem_addr = AddrW'(in_i.element_index);
  assign tgt_addr  = AddrW'(tgt_idx);
  assign src_addr  = AddrW'(src_idx);

  // Mode registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transpose_q <= 1'b0;
      subtract_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        coo_smv_pkg::REG_TRANSPOSE: transpose_q <= cfg_data_i[0];
        coo_smv_pkg::REG_SUBTRACT:  subtract_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= coo_smv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and strobes
  always_comb begin
    state_d    = state_q;
    in_ready   = 1'b0;
    x_we       = 1'b0;
    x_re       = 1'b0;
    acc_pre_we = 1'b0;
    acc_re     = 1'b0;
    mac_ctrl   = '{valid: 1'b0, subtract: subtract_q};
    out_load   = 1'b0;
    case (state_q)
      coo_smv_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          case (op)
            coo_smv_pkg::OP_WRITE_X: x_we = elem_ok;
            coo_smv_pkg::OP_PRESET:  acc_pre_we = elem_ok;
            coo_smv_pkg::OP_NONZERO: begin
              if (nz_ok) begin
                x_re    = 1'b1;
                acc_re  = 1'b1;
                state_d = coo_smv_pkg::ST_MUL;
              end
            end
            coo_smv_pkg::OP_READ: begin
              acc_re  = elem_ok;
              state_d = coo_smv_pkg::ST_RESP;
            end
            default: ;
          endcase
        end
      end
      coo_smv_pkg::ST_MUL: begin
        mac_ctrl.valid = 1'b1;
        state_d        = coo_smv_pkg::ST_ACC;
      end
      coo_smv_pkg::ST_ACC: begin
        state_d = coo_smv_pkg::ST_IDLE;
      end
      coo_smv_pkg::ST_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = coo_smv_pkg::ST_IDLE;
        end
      end
      default: state_d = coo_smv_pkg::ST_IDLE;
    endcase
  end

  // Per-command payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      value_q <= in_i.value;
      tgt_q   <= tgt_addr;
      rd_ok_q <= elem_ok;
    end
  end

  // Input vector store
  coo_smv_ram #(
    .DEPTH  (VEC_DEPTH),
    .ADDR_W (AddrW),
    .WIDTH  (DataW)
  ) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (elem_addr),
    .wdata_i (in_i.value),
    .re_i    (x_re),
    .raddr_i (src_addr),
    .rdata_o (x_rdata)
  );

  // Accumulator store: preset or MAC write back
  assign acc_we    = acc_pre_we || mac_res.valid;
  assign acc_waddr = mac_res.valid ? tgt_q : elem_addr;
  assign acc_wdata = mac_res.valid ? mac_res.sum : in_i.value;
  assign acc_raddr = (op == coo_smv_pkg::OP_NONZERO) ? tgt_addr : elem_addr;

  coo_smv_ram #(
    .DEPTH  (VEC_DEPTH),
    .ADDR_W (AddrW),
    .WIDTH  (DataW)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  coo_smv_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .value_i (value_q),
    .x_i     (x_rdata),
    .acc_i   (acc_rdata),
    .res_o   (mac_res)
  );

  // Sticky saturation flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_flag_q <= 1'b0;
    end else if (mac_res.valid && mac_res.sat) begin
      sat_flag_q <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      read_value_q <= rd_ok_q ? acc_rdata : '0;
      overflow_q   <= sat_flag_q;
    end
  end

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.read_value    = read_value_q;
  assign out_o.overflow_seen = overflow_q;

  // Checks
  `COO_SMV_ASSERT(a_wb_after_mul, mac_res.valid |-> $past(state_q == coo_smv_pkg::ST_MUL),
    "accumulator write back without a multiply cycle")
  `COO_SMV_ASSERT(a_sat_sticky, !$fell(sat_flag_q),
    "saturation flag cleared outside reset")
  `COO_SMV_ASSERT_ALWAYS(a_acc_one_writer, !(acc_pre_we && mac_res.valid),
    "preset and write back hit the accumulator in one cycle")
  `COO_SMV_ASSERT(a_resp_waits,
    (state_q == coo_smv_pkg::ST_RESP && out_valid_q && !out_o.ready)
      |=> (state_q == coo_smv_pkg::ST_RESP),
    "read result dropped while output register was full")

endmodule
